// File: hw/rtl/binary_to_intel_hex_encoder_unit_assert.svh
// ---------------------------------------------------------------------------
// Intel HEX encoder assertion macros
// Shared property templates for the encoder's checker.
// ---------------------------------------------------------------------------
`ifndef BINARY_TO_INTEL_HEX_ENCODER_UNIT_ASSERT_SVH
`define BINARY_TO_INTEL_HEX_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while dis is high.
`define BHEX_ASSERT_NOW(label, clk, dis, a, b) \
  label: assert property (@(posedge clk) disable iff (dis) (a) |-> (b)) \
    else $error("bhex: implication failed");

// Next-cycle implication, disabled while dis is high.
`define BHEX_ASSERT_NEXT(label, clk, dis, a, b) \
  label: assert property (@(posedge clk) disable iff (dis) (a) |=> (b)) \
    else $error("bhex: next-cycle implication failed");

`endif

// File: hw/rtl/bhex_pkg.sv
// ---------------------------------------------------------------------------
// Intel HEX encoder package
// Shared types, codes and character helpers.
// ---------------------------------------------------------------------------
package bhex_pkg;

  localparam int RECORD_BYTES_DEFAULT = 16;
  localparam int HDR_BYTES            = 4;   // count, address high, address low, type
  localparam int ADDR_W               = 16;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NL      = 8'h0A;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_FINAL = 2'd1,
    OP_END   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_beat_t;

  // Upper-case ASCII hex digit.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + {4'h0, nib};
    end
    return 8'h37 + {4'h0, nib};
  endfunction

endpackage

// File: hw/rtl/bhex_out_reg.sv
// ---------------------------------------------------------------------------
// Intel HEX encoder output register
// Holds one character for the downstream stream, frees on transfer.
// ---------------------------------------------------------------------------
module bhex_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bhex_pkg::out_beat_t  beat,
  output logic                 space,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [7:0] out_char
  output logic                 m_axis_tlast    // last_char
);
  import bhex_pkg::*;

  assign space = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (space) begin
      m_axis_tvalid <= push;
    end
  end

  // Payload: load on a new character only.
  always_ff @(posedge clk) begin
    if (push && space) begin
      m_axis_tdata <= beat.ch;
      m_axis_tlast <= beat.last;
    end
  end

endmodule

// File: hw/rtl/binary_to_intel_hex_encoder_unit.sv
// ---------------------------------------------------------------------------
// Intel HEX record encoder
// Gathers raw bytes into a record buffer and streams Intel HEX text.
// ---------------------------------------------------------------------------
//
// Channel   Dir  Fields (low bit first)                 Transfer
// s_axis    in   tdata: data_byte[7:0]                  tvalid & tready
//                tuser: operation[1:0]
// m_axis    out  tdata: out_char[7:0], tlast: last_char tvalid & tready
// cfg       in   cfg_wr_data: start_address[15:0]       cfg_wr_en
//
// An input byte that completes no record leaves s_axis ready for the next
// item. An item that emits records sends its text one character at a time:
// 2*n+12 characters for a data record of n bytes and 12 for the end record,
// paced by the single character sequencer and the buffer's one read port.
// Reset (rst, synchronous) clears the fill count and stream flag and loads
// the address registers with zero; the buffer itself is not cleared.
// A stalled m_axis holds the sequencer; s_axis is ready only between items,
// including while the last character of the previous item still waits.
// ---------------------------------------------------------------------------
module binary_to_intel_hex_encoder_unit #(
  parameter int RECORD_BYTES = bhex_pkg::RECORD_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,     // [15:0] start_address
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,    // [1:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,    // [7:0] out_char
  output logic        m_axis_tlast     // last_char
);
  import bhex_pkg::*;

  localparam int AW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam int CW = $clog2(RECORD_BYTES + 1);
  localparam int PW = $clog2(RECORD_BYTES + HDR_BYTES + 1);
  localparam logic [CW-1:0] FULL  = CW'(RECORD_BYTES);
  localparam logic [PW-1:0] P_CNT = PW'(0);
  localparam logic [PW-1:0] P_AHI = PW'(1);
  localparam logic [PW-1:0] P_ALO = PW'(2);
  localparam logic [PW-1:0] P_TYP = PW'(3);
  localparam logic [PW-1:0] P_DAT = PW'(HDR_BYTES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COLON,
    S_HI,
    S_LO,
    S_NL
  } state_t;

  state_t              state;
  logic [CW-1:0]       fill;
  logic                in_stream;
  logic [ADDR_W-1:0]   start_addr;
  logic [ADDR_W-1:0]   rec_addr;
  logic [CW-1:0]       rec_count;     // bytes in the record being sent
  logic                rec_end;       // sending the end record
  logic                end_after;     // end record follows this data record
  logic [PW-1:0]       pos;           // byte position inside the record
  logic [7:0]          sum;
  logic [CW-1:0]       data_ptr;      // buffer read address
  logic [7:0]          buf_mem [RECORD_BYTES];
  logic [7:0]          rd_data;

  logic                in_fire;
  op_t                 op;
  logic [CW-1:0]       fill_next;
  logic [PW-1:0]       csum_pos;
  logic [7:0]          byte_val;
  logic                space;
  out_beat_t           beat;
  logic                adv;

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign op            = op_t'(s_axis_tuser);
  assign fill_next     = fill + CW'(1);
  assign csum_pos      = P_DAT + PW'(rec_count);
  assign adv           = (state != S_IDLE) && space;

  // Record buffer: one write port from the input, one read port for the
  // sequencer. An item's byte is written at its accept edge, before the
  // sequencer reaches the data field, so no forwarding is needed.
  // Hold the read data while a low digit waits on the output.
  always_ff @(posedge clk) begin
    if (in_fire && (op == OP_DATA || op == OP_FINAL)) begin
      buf_mem[fill[AW-1:0]] <= s_axis_tdata;
    end
    if (state != S_LO || adv) begin
      rd_data <= buf_mem[data_ptr[AW-1:0]];
    end
  end

  // Byte shown at the current position.
  always_comb begin
    priority if (pos == P_CNT) begin
      byte_val = 8'(rec_count);
    end else if (pos == P_AHI) begin
      byte_val = rec_end ? 8'h00 : rec_addr[15:8];
    end else if (pos == P_ALO) begin
      byte_val = rec_end ? 8'h00 : rec_addr[7:0];
    end else if (pos == P_TYP) begin
      byte_val = {7'd0, rec_end};
    end else if (pos < csum_pos) begin
      byte_val = rd_data;
    end else begin
      byte_val = 8'h00 - sum;   // two's-complement checksum
    end
  end

  always_comb begin
    unique case (state)
      S_COLON: beat.ch = CHAR_COLON;
      S_HI:    beat.ch = hex_char(byte_val[7:4]);
      S_LO:    beat.ch = hex_char(byte_val[3:0]);
      S_NL:    beat.ch = CHAR_NL;
      default: beat.ch = 8'h00;
    endcase
    beat.last = (state == S_NL) && (rec_end || !end_after);
  end

  // Sequencer: input decode, record start and one character per advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      in_stream  <= 1'b0;
      start_addr <= '0;
      rec_addr   <= '0;
      rec_count  <= '0;
      rec_end    <= 1'b0;
      end_after  <= 1'b0;
      pos        <= '0;
      sum        <= '0;
      data_ptr   <= '0;
    end else begin
      // Register write: take the address now unless a stream is open.
      if (cfg_wr_en) begin
        start_addr <= cfg_wr_data;
        if (!in_stream) begin
          rec_addr <= cfg_wr_data;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            unique case (op)
              OP_DATA: begin
                in_stream <= 1'b1;
                if (fill_next == FULL) begin
                  state     <= S_COLON;
                  pos       <= '0;
                  sum       <= '0;
                  data_ptr  <= '0;
                  rec_count <= FULL;
                  rec_end   <= 1'b0;
                  end_after <= 1'b0;
                  fill      <= '0;
                end else begin
                  fill <= fill_next;
                end
              end
              OP_FINAL: begin
                state     <= S_COLON;
                pos       <= '0;
                sum       <= '0;
                data_ptr  <= '0;
                rec_count <= fill_next;
                rec_end   <= 1'b0;
                end_after <= 1'b1;
                fill      <= '0;
                in_stream <= 1'b0;
              end
              OP_END: begin
                state     <= S_COLON;
                pos       <= '0;
                sum       <= '0;
                data_ptr  <= '0;
                fill      <= '0;
                in_stream <= 1'b0;
                if (fill != '0) begin
                  rec_count <= fill;
                  rec_end   <= 1'b0;
                  end_after <= 1'b1;
                end else begin
                  // Empty buffer: end record only.
                  rec_count <= '0;
                  rec_end   <= 1'b1;
                  end_after <= 1'b0;
                  rec_addr  <= start_addr;
                end
              end
              OP_NONE: begin
                // Drop the item.
              end
            endcase
          end
        end
        S_COLON: begin
          if (adv) begin
            state <= S_HI;
          end
        end
        S_HI: begin
          if (adv) begin
            state <= S_LO;
            if (pos < csum_pos) begin
              sum <= sum + byte_val;
            end
            // Advance the read address once its byte is on show.
            if (pos >= P_DAT && pos < csum_pos) begin
              data_ptr <= data_ptr + CW'(1);
            end
          end
        end
        S_LO: begin
          if (adv) begin
            if (pos == csum_pos) begin
              state <= S_NL;
            end else begin
              pos   <= pos + PW'(1);
              state <= S_HI;
            end
          end
        end
        S_NL: begin
          if (adv) begin
            if (!rec_end) begin
              rec_addr <= end_after ? start_addr : rec_addr + ADDR_W'(rec_count);
            end
            if (rec_end || !end_after) begin
              state <= S_IDLE;
            end else begin
              // Chain the end record behind the data record.
              state     <= S_COLON;
              pos       <= '0;
              sum       <= '0;
              rec_count <= '0;
              rec_end   <= 1'b1;
              end_after <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  bhex_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .push          (state != S_IDLE),
    .beat          (beat),
    .space         (space),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: hw/rtl/bhex_checker.sv
// ---------------------------------------------------------------------------
// Intel HEX encoder checker
// Port-level properties of the encoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "binary_to_intel_hex_encoder_unit_assert.svh"

module bhex_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);
  import bhex_pkg::*;

  // A waiting character holds until it is taken.
  `BHEX_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

  // Output is empty right after reset.
  `BHEX_ASSERT_NEXT(a_rst_empty, clk, 1'b0, rst, !m_axis_tvalid)

  // Every item's text ends in a newline.
  `BHEX_ASSERT_NOW(a_last_nl, clk, rst, m_axis_tvalid && m_axis_tlast, m_axis_tdata == CHAR_NL)

  // No new item while a record is still being sent.
  `BHEX_ASSERT_NOW(a_busy_block, clk, rst, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

endmodule

bind binary_to_intel_hex_encoder_unit bhex_checker u_bhex_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// File: dv/intel_hex_stream_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Intel HEX encoder stream checker
// Observes the config port and both stream channels, predicts the HEX text
// for every accepted input transfer and compares it character by character.
// ---------------------------------------------------------------------------
module intel_hex_stream_checker #(
  parameter int RECORD_BYTES = bhex_pkg::RECORD_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          chars_pending,
  output int          chars_checked
);
  import bhex_pkg::*;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;

  logic [7:0]  byte_store [16];
  logic [4:0]  bytes_held;
  logic [15:0] start_addr;
  logic [15:0] load_addr;
  logic        stream_open;
  out_beat_t   char_queue [$];

  initial begin
    fail_count    = 0;
    chars_pending = 0;
    chars_checked = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [7:0] ascii_digit(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    return (nib > 4'd9) ? (8'h41 + wide - 8'd10) : (8'h30 + wide);
  endfunction

  task automatic push_char(input logic [7:0] c);
    out_beat_t beat;
    beat.ch   = c;
    beat.last = 1'b0;
    char_queue.push_back(beat);
  endtask

  task automatic push_pair(input logic [7:0] v);
    push_char(ascii_digit(v[7:4]));
    push_char(ascii_digit(v[3:0]));
  endtask

  // Queue one record; an end record ignores the count and the address.
  task automatic emit_record(input logic [4:0] count, input logic end_rec);
    logic [7:0] n8;
    logic [7:0] addr_hi;
    logic [7:0] addr_lo;
    logic [7:0] rec_type;
    logic [7:0] sum;
    int         i;
    n8       = end_rec ? 8'h00 : {3'b000, count};
    addr_hi  = end_rec ? 8'h00 : load_addr[15:8];
    addr_lo  = end_rec ? 8'h00 : load_addr[7:0];
    rec_type = end_rec ? REC_EOF : REC_DATA;
    sum      = n8 + addr_hi + addr_lo + rec_type;
    push_char(CHAR_COLON);
    push_pair(n8);
    push_pair(addr_hi);
    push_pair(addr_lo);
    push_pair(rec_type);
    for (i = 0; i < int'(n8); i++) begin
      sum = sum + byte_store[i];
      push_pair(byte_store[i]);
    end
    push_pair(8'h00 - sum);
    push_char(CHAR_NL);
    if (!end_rec) begin
      load_addr = load_addr + {8'h00, n8};
    end
  endtask

  task automatic encode_item(input op_t op, input logic [7:0] data);
    int        q_start;
    out_beat_t tail;
    q_start = char_queue.size();
    if (op == OP_DATA || op == OP_FINAL) begin
      byte_store[bytes_held[3:0]] = data;
      bytes_held  = bytes_held + 5'd1;
      stream_open = 1'b1;
      if (bytes_held >= 5'(RECORD_BYTES)) begin
        emit_record(5'(RECORD_BYTES), 1'b0);
        bytes_held = 5'd0;
      end
    end
    if (op == OP_FINAL || op == OP_END) begin
      if (bytes_held != 5'd0) begin
        emit_record(bytes_held, 1'b0);
      end
      emit_record(5'd0, 1'b1);
      bytes_held  = 5'd0;
      stream_open = 1'b0;
      load_addr   = start_addr;
    end
    if (char_queue.size() > q_start) begin
      tail      = char_queue.pop_back();
      tail.last = 1'b1;
      char_queue.push_back(tail);
    end
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      bytes_held  = 5'd0;
      stream_open = 1'b0;
      start_addr  = 16'h0000;
      load_addr   = 16'h0000;
      char_queue.delete();
    end else begin
      // Output first: a character at this edge belongs to an earlier item.
      if (m_axis_tvalid && m_axis_tready) begin
        if (char_queue.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h with nothing expected", m_axis_tdata));
        end else begin
          want = char_queue.pop_front();
          chars_checked++;
          if (m_axis_tdata !== want.ch) begin
            report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                      m_axis_tdata, want.ch));
          end
          if (m_axis_tlast !== want.last) begin
            report_mismatch($sformatf("last_char %b, expected %b on char 0x%02h",
                                      m_axis_tlast, want.last, want.ch));
          end
        end
      end
      if (cfg_wr_en) begin
        start_addr = cfg_wr_data;
        if (!stream_open) begin
          load_addr = cfg_wr_data;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        encode_item(op_t'(s_axis_tuser), s_axis_tdata);
      end
    end
    chars_pending = char_queue.size();
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Intel HEX encoder testbench
// Drives byte streams and start-address settings into the encoder, stalls
// both channels at random and leaves prediction and comparison to the
// stream checker; a watchdog ends a run that stops making progress.
// ---------------------------------------------------------------------------
module tb_top;
  import bhex_pkg::*;

  localparam int REC_BYTES     = RECORD_BYTES_DEFAULT;
  localparam int RANDOM_ITEMS  = 80;
  localparam int MAX_IDLE      = 18;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 40;
  localparam int STALL_LIMIT   = 2000; // cycles without any transfer

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_wr_en     = 1'b0;
  logic [15:0] cfg_wr_data   = 16'h0000;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] data_byte
  logic [1:0]  s_axis_tuser  = OP_DATA; // [1:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;            // [7:0] out_char
  logic        m_axis_tlast;            // last_char

  int fail_count;
  int chars_pending;
  int chars_checked;

  // Shared stimulus controls and counters.
  bit no_idle      = 1'b0;
  int items_sent   = 0;
  int streams_done = 0;
  int start_writes = 0;
  int stall_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  binary_to_intel_hex_encoder_unit #(
    .RECORD_BYTES (REC_BYTES)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  intel_hex_stream_checker #(
    .RECORD_BYTES (REC_BYTES)
  ) u_stream_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .chars_pending (chars_pending),
    .chars_checked (chars_checked)
  );

  // Watchdog: count cycles in which neither channel moves a transfer.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t ns: watchdog expired, no transfer for %0d cycles", $time, stall_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Send one item. Called at a falling edge; returns at the falling edge
  // after the transfer with tvalid still high, so a back-to-back item
  // keeps it up without a second assignment in the same step.
  task automatic send_item(input op_t op, input logic [7:0] data);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = data;
    s_axis_tuser  = op;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    if (op != OP_NONE) begin
      items_sent++;
    end
    if (op == OP_FINAL || op == OP_END) begin
      streams_done++;
    end
  endtask

  // Hold the sender until every predicted character has arrived, then
  // let a zero-result item finish inside the block.
  task automatic settle_results();
    s_axis_tvalid = 1'b0;
    while (chars_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write start_address; only called once the block is idle.
  task automatic write_start(input logic [15:0] addr);
    cfg_wr_data = addr;
    cfg_wr_en   = 1'b1;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    start_writes++;
  endtask

  // Receiver: draw a stall for every character, then accept it.
  initial begin : sink
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int          directed_items;
    int          phase;
    int          len;
    int          i;
    bit          mid_write;
    logic [15:0] addr;

    repeat (9) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // ---- Directed part ----
    // End of stream with an empty buffer: only the end record.
    write_start(16'h0000);
    send_item(OP_END, 8'h5A);
    // Reserved operation: accepted, dropped without output.
    send_item(OP_NONE, 8'hFF);
    settle_results();

    // Short stream at the top of the address space; pause mid-stream and
    // move the start address, which must not touch the open stream.
    write_start(16'hFFFF);
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'hFF);
    settle_results();
    write_start(16'h1234);
    send_item(OP_FINAL, 8'h80);
    settle_results();

    // Final byte that fills a record: full record then end record in one item.
    for (i = 0; i < REC_BYTES - 1; i++) begin
      send_item(OP_DATA, 8'($urandom_range(0, 255)));
    end
    send_item(OP_FINAL, 8'hC3);
    directed_items = items_sent;

    // ---- Random part: mostly well-formed streams with random bytes ----
    phase = 0;
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      settle_results();
      case (phase % 5)
        0:       addr = 16'h0000;
        1:       addr = 16'hFFFF;
        2:       addr = 16'hFFF0 + 16'($urandom_range(0, 15)); // wraps mid-stream
        default: addr = 16'($urandom_range(0, 65535));
      endcase
      write_start(addr);
      no_idle   = (phase % 4 == 3);
      mid_write = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 2) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);

      // Broken sequence now and then: an end marker before any data.
      if ($urandom_range(0, 9) == 0) begin
        send_item(OP_END, 8'($urandom_range(0, 255)));
      end
      for (i = 0; i < len - 1; i++) begin
        if ($urandom_range(0, 11) == 0) begin
          send_item(OP_NONE, 8'($urandom_range(0, 255)));
        end
        send_item(OP_DATA, 8'($urandom_range(0, 255)));
        if (mid_write && i == len / 2) begin
          settle_results();
          write_start(16'($urandom_range(0, 65535)));
        end
      end
      // Close either with a final byte or with a byte and a bare end marker.
      if ($urandom_range(0, 1) == 0) begin
        send_item(OP_FINAL, 8'($urandom_range(0, 255)));
      end else begin
        send_item(OP_DATA, 8'($urandom_range(0, 255)));
        send_item(OP_END, 8'($urandom_range(0, 255)));
      end
      phase++;
    end

    // Drain, then watch the idle output for stray characters.
    no_idle = 1'b0;
    settle_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d input items in %0d streams, %0d characters compared.",
             items_sent, streams_done, chars_checked);
    $display("Start address written %0d times, incl. 0x0000, 0xFFFF and wrap cases.",
             start_writes);
    if (fail_count == 0 && chars_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: binary_to_intel_hex_encoder_unit.f
+incdir+hw/rtl
hw/rtl/bhex_pkg.sv
hw/rtl/bhex_out_reg.sv
hw/rtl/binary_to_intel_hex_encoder_unit.sv
hw/rtl/bhex_checker.sv
dv/intel_hex_stream_checker.sv
dv/tb_top.sv
